@@ rtl/jild_pkg.sv @@
package jild_pkg;

    // Default width of the code position counter
    localparam int ADDR_BITS_DEF = 16;

    localparam int CODE_W  = 8;
    localparam int ADDR_W  = 16;
    localparam int LEN_W   = 16;

    localparam logic [CODE_W-1:0] OP_LAST_VALID = 8'hc9;

    // Opcodes with their own length rules
    localparam logic [CODE_W-1:0] OP_IINC         = 8'h84;
    localparam logic [CODE_W-1:0] OP_TABLESWITCH  = 8'haa;
    localparam logic [CODE_W-1:0] OP_LOOKUPSWITCH = 8'hab;
    localparam logic [CODE_W-1:0] OP_WIDE         = 8'hc4;

    // One finished instruction
    typedef struct packed {
        logic                length_overflow;
        logic                bad_opcode;
        logic [LEN_W-1:0]    instr_length;
        logic [ADDR_W-1:0]   start_address;
        logic [CODE_W-1:0]   opcode;
    } t_result;

endpackage

@@ rtl/jvm_instruction_length_decoder_unit.sv @@
// Channel   Dir  tdata                               tuser
// s (in)    in   [7:0] code_byte                     [0] start_of_code
// m (out)   out  [7:0] opcode, [23:8] start_address, [0] bad_opcode,
//                [39:24] instr_length                [1] length_overflow
//
// One code byte is taken per cycle while tready; a word is accepted on s when tvalid and tready.
// An instruction's result appears on m the cycle after its last byte is accepted.
// The parse step is single pass: position, phase and counters update each accepted byte.
// Reset (i_rst_n low, synchronous) clears the parse state and empties the output register.
// s stays ready while the output register is empty or being drained by m.
module jvm_instruction_length_decoder_unit #(
    parameter int ADDR_BITS = jild_pkg::ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] code_byte
    input  logic        i_s_tuser,   // [0] start_of_code
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] opcode, [23:8] start_address, [39:24] instr_length
    output logic [1:0]  o_m_tuser    // [0] bad_opcode, [1] length_overflow
);
    import jild_pkg::*;

    logic     accept;
    logic     res_valid;
    t_result  res;
    logic     r_out_valid;
    t_result  r_out;

    // Take a new byte whenever the output slot is free or leaving this cycle
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    jild_parser #(
        .ADDR_BITS(ADDR_BITS)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_code_byte     (i_s_tdata),
        .i_start_of_code (i_s_tuser),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // Output register: load a finished instruction, drop the slot once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.instr_length, r_out.start_address, r_out.opcode};
    assign o_m_tuser  = {r_out.length_overflow, r_out.bad_opcode};

    // A pending word never holds a zero length
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.instr_length != '0)
        else $error("zero instruction length emitted");

    // A flagged opcode is always a one-byte instruction
    a_bad_len_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.bad_opcode) |-> r_out.instr_length == 16'd1)
        else $error("bad opcode with length other than one");

    // Overflow only comes with a saturated length
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.length_overflow) |-> r_out.instr_length == 16'hffff)
        else $error("length overflow without saturated length");

    // A result produced while the slot is full and stalled would be lost
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !res_valid)
        else $error("result produced while output stalled");

endmodule

@@ rtl/jild_parser.sv @@
module jild_parser #(
    parameter int ADDR_BITS = jild_pkg::ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [jild_pkg::CODE_W-1:0]   i_code_byte,
    input  logic                          i_start_of_code,
    output logic                          o_res_valid,
    output jild_pkg::t_result             o_res
);
    import jild_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_FIXED,
        PH_WIDE,
        PH_HDR,
        PH_ENTRIES
    } t_phase;

    // Fixed operand byte count per opcode
    function automatic logic [2:0] operand_bytes(input logic [7:0] op);
        logic [2:0] k;
        k = 3'd0;
        if (op == 8'h10 || op == 8'h12 || (op >= 8'h15 && op <= 8'h19) ||
            (op >= 8'h36 && op <= 8'h3a) || op == 8'ha9 || op == 8'hbc) begin
            k = 3'd1;
        end else if (op == 8'h11 || op == 8'h13 || op == 8'h14 || op == OP_IINC ||
                     (op >= 8'h99 && op <= 8'ha8) || (op >= 8'hb2 && op <= 8'hb8) ||
                     op == 8'hbb || op == 8'hbd || op == 8'hc0 || op == 8'hc1 ||
                     op == 8'hc6 || op == 8'hc7) begin
            k = 3'd2;
        end else if (op == 8'hc5) begin
            k = 3'd3;
        end else if (op == 8'hb9 || op == 8'hba || op == 8'hc8 || op == 8'hc9) begin
            k = 3'd4;
        end
        return k;
    endfunction

    logic [ADDR_BITS-1:0] r_pos,   n_pos;
    logic [ADDR_BITS-1:0] r_start, n_start;
    logic [7:0]           r_op,    n_op;
    t_phase               r_phase, n_phase;
    logic [31:0]          r_word,  n_word;
    logic [31:0]          r_low,   n_low;
    logic [31:0]          r_left,  n_left;
    logic [31:0]          r_len,   n_len;

    logic [ADDR_BITS-1:0] pos;
    t_phase               phase;
    logic                 emit;
    logic [2:0]           k;
    logic [1:0]           pad;
    logic [4:0]           hdr_len;
    logic [31:0]          left_dec;
    logic [31:0]          word_next;
    logic [33:0]          cnt;
    logic [34:0]          entry;
    logic [35:0]          sum;
    logic [31:0]          start_ext;

    always_comb begin
        pos       = i_start_of_code ? '0 : r_pos;
        phase     = i_start_of_code ? PH_OPCODE : r_phase;
        n_pos     = pos + {{(ADDR_BITS-1){1'b0}}, 1'b1};
        n_start   = r_start;
        n_op      = r_op;
        n_phase   = phase;
        n_word    = r_word;
        n_low     = r_low;
        n_left    = r_left;
        n_len     = r_len;
        emit      = 1'b0;
        k         = operand_bytes(i_code_byte);
        pad       = ~pos[1:0];
        hdr_len   = {3'b000, pad} + ((i_code_byte == OP_TABLESWITCH) ? 5'd12 : 5'd8);
        left_dec  = (r_left != 32'd0) ? r_left - 32'd1 : r_left;
        word_next = {r_word[23:0], i_code_byte};
        cnt       = {{2{word_next[31]}}, word_next} - {{2{r_low[31]}}, r_low} + 34'd1;
        entry     = '0;
        if (r_op == OP_TABLESWITCH) begin
            if (!cnt[33] && cnt != 34'd0) begin
                entry = {cnt[32:0], 2'b00};
            end
        end else if (!word_next[31] && word_next != 32'd0) begin
            entry = {1'b0, word_next[30:0], 3'b000};
        end
        sum = {4'b0000, r_len} + {1'b0, entry};

        case (phase)
            PH_OPCODE: begin
                n_op    = i_code_byte;
                n_start = pos;
                if (i_code_byte > OP_LAST_VALID) begin
                    n_len   = 32'd1;
                    n_phase = PH_OPCODE;
                    emit    = 1'b1;
                end else if (i_code_byte == OP_WIDE) begin
                    n_phase = PH_WIDE;
                end else if (i_code_byte == OP_TABLESWITCH ||
                             i_code_byte == OP_LOOKUPSWITCH) begin
                    n_left  = 32'(hdr_len);
                    n_len   = 32'(hdr_len) + 32'd1;
                    n_word  = '0;
                    n_phase = PH_HDR;
                end else begin
                    n_len = 32'(k) + 32'd1;
                    if (k == 3'd0) begin
                        n_phase = PH_OPCODE;
                        emit    = 1'b1;
                    end else begin
                        n_left  = 32'(k);
                        n_phase = PH_FIXED;
                    end
                end
            end
            PH_WIDE: begin
                if (i_code_byte == OP_IINC) begin
                    n_len  = 32'd6;
                    n_left = 32'd4;
                end else begin
                    n_len  = 32'd4;
                    n_left = 32'd2;
                end
                n_phase = PH_FIXED;
            end
            PH_FIXED, PH_ENTRIES: begin
                n_left = left_dec;
                if (left_dec == 32'd0) begin
                    n_phase = PH_OPCODE;
                    emit    = 1'b1;
                end
            end
            PH_HDR: begin
                n_word = word_next;
                n_left = left_dec;
                if (r_op == OP_TABLESWITCH && left_dec == 32'd4) begin
                    n_low = word_next;
                end else if (left_dec == 32'd0) begin
                    // Add the table size, saturating at 32 bits
                    n_len = (sum[35:32] != 4'd0) ? '1 : sum[31:0];
                    if (entry == 35'd0) begin
                        n_phase = PH_OPCODE;
                        emit    = 1'b1;
                    end else begin
                        n_left  = (entry[34:32] != 3'd0) ? '1 : entry[31:0];
                        n_phase = PH_ENTRIES;
                    end
                end
            end
            default: begin
                n_phase = PH_OPCODE;
            end
        endcase

        start_ext                 = 32'(n_start);
        o_res_valid               = i_accept & emit;
        o_res.opcode              = n_op;
        o_res.start_address       = start_ext[ADDR_W-1:0];
        o_res.instr_length        = (n_len > 32'h0000_ffff) ? '1 : n_len[LEN_W-1:0];
        o_res.bad_opcode          = n_op > OP_LAST_VALID;
        o_res.length_overflow     = n_len > 32'h0000_ffff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_start <= '0;
            r_op    <= '0;
            r_phase <= PH_OPCODE;
            r_word  <= '0;
            r_low   <= '0;
            r_left  <= '0;
            r_len   <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_start <= n_start;
            r_op    <= n_op;
            r_phase <= n_phase;
            r_word  <= n_word;
            r_low   <= n_low;
            r_left  <= n_left;
            r_len   <= n_len;
        end
    end

endmodule
